// ----- src/mcfc_pkg.sv -----
// Shared types and constants for the motor CAN frame codec.
// No dependencies; every module file imports this package.
package mcfc_pkg;

    localparam int LANES   = 5;
    localparam int NUM_W   = 65;
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 33;
    localparam int X_W     = 49;
    localparam int LIM_W   = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [2:0] OP_MIT     = 3'd0;
    localparam logic [2:0] OP_ENABLE  = 3'd1;
    localparam logic [2:0] OP_DISABLE = 3'd2;
    localparam logic [2:0] OP_ZERO    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_FB      = 3'd5;

    localparam logic [7:0] BYTE_ENABLE  = 8'hFC;
    localparam logic [7:0] BYTE_DISABLE = 8'hFD;
    localparam logic [7:0] BYTE_ZERO    = 8'hFE;
    localparam logic [7:0] BYTE_CLEAR   = 8'hFB;
    localparam logic [55:0] CMD_FILL    = 56'hFF_FFFF_FFFF_FFFF;

    localparam logic [1:0]  MODE_POS   = 2'd1;
    localparam logic [1:0]  MODE_SPEED = 2'd2;
    localparam logic [10:0] OFFS_POS   = 11'h100;
    localparam logic [10:0] OFFS_SPEED = 11'h200;

    localparam logic [2:0] REG_CAN_ID    = 3'd0;
    localparam logic [2:0] REG_CTRL_MODE = 3'd1;
    localparam logic [2:0] REG_POS_LIM   = 3'd2;
    localparam logic [2:0] REG_VEL_LIM   = 3'd3;
    localparam logic [2:0] REG_TRQ_LIM   = 3'd4;
    localparam logic [2:0] REG_KP_MAX    = 3'd5;
    localparam logic [2:0] REG_KD_MAX    = 3'd6;

    localparam logic [10:0]      RST_CAN_ID  = 11'd1;
    localparam logic [1:0]       RST_MODE    = 2'd0;
    localparam logic [LIM_W-1:0] RST_POS_LIM = 31'd819200;
    localparam logic [LIM_W-1:0] RST_VEL_LIM = 31'd1966080;
    localparam logic [LIM_W-1:0] RST_TRQ_LIM = 31'd655360;
    localparam logic [LIM_W-1:0] RST_KP_MAX  = 31'd32768000;
    localparam logic [LIM_W-1:0] RST_KD_MAX  = 31'd327680;

    typedef enum logic [1:0] {
        K_MIT,
        K_CMD,
        K_FB
    } t_kind;

    typedef struct packed {
        logic [10:0]      can_id;
        logic [1:0]       ctrl_mode;
        logic [LIM_W-1:0] pos_limit;
        logic [LIM_W-1:0] vel_limit;
        logic [LIM_W-1:0] torque_limit;
        logic [LIM_W-1:0] kp_max;
        logic [LIM_W-1:0] kd_max;
    } t_cfg;

    typedef struct packed {
        t_kind                       kind;
        logic [7:0]                  cmd_byte;
        logic [10:0]                 std_id;
        logic [3:0]                  err;
        logic [7:0]                  temp_mos;
        logic [7:0]                  temp_rotor;
        logic [LANES-1:0]            sat_lo;
        logic [LANES-1:0]            sat_hi;
        logic [LANES-1:0][LIM_W-1:0] lim;
    } t_side;

    typedef struct packed {
        t_side                       side;
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [LANES-1:0][DEN_W-1:0] den;
    } t_job;

    // A range register of zero acts as one.
    function automatic logic [LIM_W-1:0] lim_nz(input logic [LIM_W-1:0] v);
        return (v == '0) ? LIM_W'(1) : v;
    endfunction

endpackage

// ----- src/mcfc_in_if.sv -----
// Input channel of the codec: valid/ready handshake and one command item.
// Depends on nothing.
interface mcfc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic signed [31:0] pos_target;
    logic signed [31:0] vel_target;
    logic [30:0] kp_gain;
    logic [30:0] kd_gain;
    logic signed [31:0] torque_ff;
    logic [63:0] rx_frame;

    modport source (output valid, op, pos_target, vel_target, kp_gain, kd_gain,
                    torque_ff, rx_frame, input ready);
    modport sink   (input valid, op, pos_target, vel_target, kp_gain, kd_gain,
                    torque_ff, rx_frame, output ready);
endinterface

// ----- src/mcfc_out_if.sv -----
// Output channel of the codec: valid/ready handshake and one result item.
// Depends on nothing.
interface mcfc_out_if;
    logic        valid;
    logic        ready;
    logic        is_feedback;
    logic [10:0] std_id;
    logic [63:0] tx_frame;
    logic [3:0]  error_code;
    logic signed [31:0] angle;
    logic signed [31:0] speed;
    logic signed [31:0] torque;
    logic [7:0]  temp_mos;
    logic [7:0]  temp_rotor;

    modport source (output valid, is_feedback, std_id, tx_frame, error_code, angle,
                    speed, torque, temp_mos, temp_rotor, input ready);
    modport sink   (input valid, is_feedback, std_id, tx_frame, error_code, angle,
                    speed, torque, temp_mos, temp_rotor, output ready);
endinterface

// ----- src/mcfc_front.sv -----
// Front end: accepts items, classifies them and prepares divider jobs.
// Depends on mcfc_pkg and mcfc_in_if.
module mcfc_front import mcfc_pkg::*; #(
    parameter int POS_BITS   = 16,
    parameter int FIELD_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcfc_in_if.sink    i_in,
    input  t_cfg       i_cfg,
    output t_job       o_job,
    output logic       o_job_valid,
    input  logic       i_job_ready
);

    localparam logic [15:0] M_POS = 16'((1 << POS_BITS) - 1);
    localparam logic [11:0] M_FLD = 12'((1 << FIELD_BITS) - 1);

    logic [LIM_W-1:0] w_pl, w_vl, w_tl, w_kpl, w_kdl;
    logic [15:0]      w_c0;
    logic [11:0]      w_c1, w_c4;
    logic [46:0]      w_p0, w_p1, w_p4;
    logic [X_W-1:0]   w_n0, w_n1, w_n4;
    logic [10:0]      w_offs;
    t_kind            w_kind;
    logic [7:0]       w_cmd;
    logic             w_take;

    logic                        r_f_valid;
    t_kind                       r_kind;
    logic [7:0]                  r_cmd;
    logic [10:0]                 r_std_id;
    logic [3:0]                  r_err;
    logic [7:0]                  r_tmos, r_trot;
    logic [LANES-1:0][X_W-1:0]   r_x;
    logic [LANES-1:0][DEN_W-1:0] r_span;
    logic [LANES-1:0][LIM_W-1:0] r_lim;

    assign i_in.ready = !r_f_valid || i_job_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        w_pl  = lim_nz(i_cfg.pos_limit);
        w_vl  = lim_nz(i_cfg.vel_limit);
        w_tl  = lim_nz(i_cfg.torque_limit);
        w_kpl = lim_nz(i_cfg.kp_max);
        w_kdl = lim_nz(i_cfg.kd_max);

        // offset of the value above the bottom of its range
        w_n0 = X_W'(i_in.pos_target) + X_W'(w_pl);
        w_n1 = X_W'(i_in.vel_target) + X_W'(w_vl);
        w_n4 = X_W'(i_in.torque_ff) + X_W'(w_tl);

        // clamp received slots to the code maximum
        w_c0 = (i_in.rx_frame[55:40] > M_POS) ? M_POS : i_in.rx_frame[55:40];
        w_c1 = (i_in.rx_frame[39:28] > M_FLD) ? M_FLD : i_in.rx_frame[39:28];
        w_c4 = (i_in.rx_frame[27:16] > M_FLD) ? M_FLD : i_in.rx_frame[27:16];
        w_p0 = 47'(w_c0) * 47'(w_pl);
        w_p1 = 47'(w_c1) * 47'(w_vl);
        w_p4 = 47'(w_c4) * 47'(w_tl);

        case (i_cfg.ctrl_mode)
            MODE_POS:   w_offs = OFFS_POS;
            MODE_SPEED: w_offs = OFFS_SPEED;
            default:    w_offs = '0;
        endcase

        w_cmd = BYTE_ENABLE;
        case (i_in.op)
            OP_MIT: w_kind = K_MIT;
            OP_FB:  w_kind = K_FB;
            OP_ENABLE: begin
                w_kind = K_CMD;
                w_cmd  = BYTE_ENABLE;
            end
            OP_DISABLE: begin
                w_kind = K_CMD;
                w_cmd  = BYTE_DISABLE;
            end
            OP_ZERO: begin
                w_kind = K_CMD;
                w_cmd  = BYTE_ZERO;
            end
            OP_CLEAR: begin
                w_kind = K_CMD;
                w_cmd  = BYTE_CLEAR;
            end
            default: w_kind = K_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_in.ready) begin
            // drop unknown ops at the door
            r_f_valid <= w_take && (i_in.op inside {[OP_MIT:OP_FB]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_kind   <= w_kind;
            r_cmd    <= w_cmd;
            r_std_id <= i_cfg.can_id + w_offs;
            r_err    <= i_in.rx_frame[63:60];
            r_tmos   <= i_in.rx_frame[15:8];
            r_trot   <= i_in.rx_frame[7:0];
            if (w_kind == K_FB) begin
                r_x[0] <= X_W'(w_p0);
                r_x[1] <= X_W'(w_p1);
                r_x[2] <= '0;
                r_x[3] <= '0;
                r_x[4] <= X_W'(w_p4);
            end else begin
                r_x[0] <= w_n0;
                r_x[1] <= w_n1;
                r_x[2] <= X_W'(i_in.kp_gain);
                r_x[3] <= X_W'(i_in.kd_gain);
                r_x[4] <= w_n4;
            end
            r_span[0] <= {w_pl, 1'b0};
            r_span[1] <= {w_vl, 1'b0};
            r_span[2] <= DEN_W'(w_kpl);
            r_span[3] <= DEN_W'(w_kdl);
            r_span[4] <= {w_tl, 1'b0};
            r_lim[0]  <= w_pl;
            r_lim[1]  <= w_vl;
            r_lim[2]  <= w_kpl;
            r_lim[3]  <= w_kdl;
            r_lim[4]  <= w_tl;
        end
    end

    assign o_job_valid          = r_f_valid;
    assign o_job.side.kind       = r_kind;
    assign o_job.side.cmd_byte   = r_cmd;
    assign o_job.side.std_id     = r_std_id;
    assign o_job.side.err        = r_err;
    assign o_job.side.temp_mos   = r_tmos;
    assign o_job.side.temp_rotor = r_trot;
    assign o_job.side.lim        = r_lim;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        localparam int B = (g == 0) ? POS_BITS : FIELD_BITS;
        localparam logic [16:0] M = 17'((1 << B) - 1);
        always_comb begin
            if (r_kind == K_FB) begin
                // round(code * span / M) as (4*code*L + M) / (2*M)
                o_job.num[g]         = (NUM_W'(r_x[g]) << 2) + NUM_W'(M);
                o_job.den[g]         = DEN_W'({M, 1'b0});
                o_job.side.sat_lo[g] = 1'b0;
                o_job.side.sat_hi[g] = 1'b0;
            end else begin
                o_job.num[g]         = (NUM_W'(r_x[g]) << B) - NUM_W'(r_x[g]);
                o_job.den[g]         = r_span[g];
                o_job.side.sat_lo[g] = $signed(r_x[g]) <= $signed(X_W'(0));
                o_job.side.sat_hi[g] = $signed(r_x[g]) >= $signed(X_W'(r_span[g]));
            end
        end
    end

endmodule

// ----- src/mcfc_queue.sv -----
// Short job queue between the front end and the divider pipeline.
// Depends on mcfc_pkg.
module mcfc_queue import mcfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- src/mcfc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mcfc_pkg; numerator must be below divisor times 2^QUO_W.
module mcfc_div import mcfc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [DEN_W-1:0] w_rem, w_den;
        logic [QUO_W-1:0] w_lo, w_quo;
        logic [DEN_W:0]   w_t;
        logic             w_ge;

        if (s == 0) begin : g_first
            assign w_rem = i_num[NUM_W-1:QUO_W];
            assign w_lo  = i_num[QUO_W-1:0];
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_lo  = r_lo[s-1];
            assign w_quo = r_quo[s-1];
            assign w_den = r_den[s-1];
        end

        assign w_t  = {w_rem, w_lo[QUO_W-1]};
        assign w_ge = w_t >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? DEN_W'(w_t - {1'b0, w_den}) : w_t[DEN_W-1:0];
                r_lo[s]  <= w_lo << 1;
                r_quo[s] <= {w_quo[QUO_W-2:0], w_ge};
                r_den[s] <= w_den;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ----- src/mcfc_back.sv -----
// Back end: divider lanes, sideband delay line and the output register.
// Depends on mcfc_pkg, mcfc_out_if and mcfc_div.
module mcfc_back import mcfc_pkg::*; #(
    parameter int POS_BITS   = 16,
    parameter int FIELD_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_pop,
    mcfc_out_if.source o_out
);

    logic                         w_en;
    logic [QUO_W-1:0]             r_vld;
    t_side                        r_side [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  w_quo;
    logic [LANES-1:0][15:0]       w_code;
    t_side                        w_s;

    logic        r_out_valid;
    logic        r_is_fb;
    logic [10:0] r_std_id;
    logic [63:0] r_tx;
    logic [3:0]  r_err;
    logic [31:0] r_angle, r_speed, r_torque;
    logic [7:0]  r_tmos, r_trot;

    // whole pipeline advances while the output register can take a transfer
    assign w_en  = !r_out_valid || o_out.ready;
    assign o_pop = w_en && i_job_valid;
    assign w_s   = r_side[QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[QUO_W-2:0], i_job_valid};
            r_out_valid <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= i_job.side;
            for (int k = 1; k < QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        localparam int B = (g == 0) ? POS_BITS : FIELD_BITS;
        localparam logic [15:0] M = 16'((1 << B) - 1);

        mcfc_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (i_job.num[g]),
            .i_den (i_job.den[g]),
            .o_quo (w_quo[g])
        );

        assign w_code[g] = w_s.sat_hi[g] ? M :
                           (w_s.sat_lo[g] ? 16'd0 : 16'(w_quo[g][B-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_is_fb  <= 1'b0;
            r_std_id <= w_s.std_id;
            r_tx     <= '0;
            r_err    <= '0;
            r_angle  <= '0;
            r_speed  <= '0;
            r_torque <= '0;
            r_tmos   <= '0;
            r_trot   <= '0;
            case (w_s.kind)
                K_MIT: begin
                    r_tx <= {w_code[0], w_code[1][11:0], w_code[2][11:0],
                             w_code[3][11:0], w_code[4][11:0]};
                end
                K_FB: begin
                    r_is_fb  <= 1'b1;
                    r_std_id <= '0;
                    r_err    <= w_s.err;
                    r_angle  <= w_quo[0][31:0] - {1'b0, w_s.lim[0]};
                    r_speed  <= w_quo[1][31:0] - {1'b0, w_s.lim[1]};
                    r_torque <= w_quo[4][31:0] - {1'b0, w_s.lim[4]};
                    r_tmos   <= w_s.temp_mos;
                    r_trot   <= w_s.temp_rotor;
                end
                default: begin
                    r_tx <= {CMD_FILL, w_s.cmd_byte};
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.is_feedback = r_is_fb;
    assign o_out.std_id      = r_std_id;
    assign o_out.tx_frame    = r_tx;
    assign o_out.error_code  = r_err;
    assign o_out.angle       = r_angle;
    assign o_out.speed       = r_speed;
    assign o_out.torque      = r_torque;
    assign o_out.temp_mos    = r_tmos;
    assign o_out.temp_rotor  = r_trot;

endmodule

// ----- src/motor_can_frame_codec.sv -----
// Motor CAN frame codec: MIT command packing and feedback unpacking.
// Path from input transfer to result valid when the queue is empty:
// front register loads at the transfer, then one queue slot, 33 divider stages, output register.
// Throughput one item per cycle while the output is ready and the queue is not full.
// Synchronous reset empties the pipeline and loads register defaults.
// Depends on mcfc_pkg, the channel interfaces, front, queue and back.
module motor_can_frame_codec import mcfc_pkg::*; #(
    parameter int POS_BITS   = 16,
    parameter int FIELD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mcfc_in_if.sink               i_in,
    mcfc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job w_fr_job, w_q_job;
    logic w_fr_valid, w_q_full, w_q_empty, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.can_id       <= RST_CAN_ID;
            r_cfg.ctrl_mode    <= RST_MODE;
            r_cfg.pos_limit    <= RST_POS_LIM;
            r_cfg.vel_limit    <= RST_VEL_LIM;
            r_cfg.torque_limit <= RST_TRQ_LIM;
            r_cfg.kp_max       <= RST_KP_MAX;
            r_cfg.kd_max       <= RST_KD_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAN_ID:    r_cfg.can_id       <= i_cfg_data[10:0];
                REG_CTRL_MODE: r_cfg.ctrl_mode    <= i_cfg_data[1:0];
                REG_POS_LIM:   r_cfg.pos_limit    <= i_cfg_data;
                REG_VEL_LIM:   r_cfg.vel_limit    <= i_cfg_data;
                REG_TRQ_LIM:   r_cfg.torque_limit <= i_cfg_data;
                REG_KP_MAX:    r_cfg.kp_max       <= i_cfg_data;
                REG_KD_MAX:    r_cfg.kd_max       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcfc_front #(
        .POS_BITS   (POS_BITS),
        .FIELD_BITS (FIELD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job       (w_fr_job),
        .o_job_valid (w_fr_valid),
        .i_job_ready (!w_q_full)
    );

    mcfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_data  (w_fr_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_job),
        .o_empty (w_q_empty)
    );

    mcfc_back #(
        .POS_BITS   (POS_BITS),
        .FIELD_BITS (FIELD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_job_valid (!w_q_empty),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule
